// ===== sv/timer_prescale_compare_calc_macros.svh =====
// assertion macros for the timer prescale and compare calculator
`ifndef TIMER_PRESCALE_COMPARE_CALC_MACROS_SVH
`define TIMER_PRESCALE_COMPARE_CALC_MACROS_SVH

`ifndef SYNTHESIS

`define TPC_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tpc check failed");

`define TPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tpc check failed");

`else

`define TPC_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)

`define TPC_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== sv/tpc_pkg.sv =====
// shared types and constants for the timer prescale and compare calculator
`default_nettype none

package tpc_pkg;

    localparam int FREQ_W             = 32;
    localparam int REM_W              = 32;
    localparam int COUNT_W            = 16;
    localparam int DIV_BITS_PER_STAGE = 2;

    localparam logic [63:0] COUNT_MAX = 64'h0000_0000_0000_FFFF;

    typedef enum logic [2:0] {
        SEL_NONE    = 3'd0,
        SEL_DIV1    = 3'd1,
        SEL_DIV8    = 3'd2,
        SEL_DIV64   = 3'd3,
        SEL_DIV256  = 3'd4,
        SEL_DIV1024 = 3'd5
    } prescale_sel_t;

    typedef struct packed {
        logic                 ok;
        prescale_sel_t        sel;
        logic [COUNT_W-1:0]   count;
    } tpc_result_t;

endpackage

`default_nettype wire

// ===== sv/tpc_div_stage.sv =====
// one register stage of the restoring divider, two quotient bits per stage
`default_nettype none

module tpc_div_stage #(
    parameter int DW = 2,
    parameter int STAGE = 0,
    parameter logic [DW-1:0] DIVIDEND = '0
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic [tpc_pkg::FREQ_W-1:0] in_divisor,
    input  wire logic [tpc_pkg::REM_W-1:0]  in_rem,
    input  wire logic [DW-1:0]              in_quot,
    input  wire logic                       in_fail,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic [tpc_pkg::FREQ_W-1:0]      out_divisor,
    output logic [tpc_pkg::REM_W-1:0]       out_rem,
    output logic [DW-1:0]                   out_quot,
    output logic                            out_fail
);
    import tpc_pkg::*;

    localparam int BPS = DIV_BITS_PER_STAGE;
    // dividend bits consumed here, msb first
    localparam logic [BPS-1:0] DIGITS = DIVIDEND[DW-1-STAGE*BPS -: BPS];

    logic                 valid_reg;
    logic [FREQ_W-1:0]    divisor_reg;
    logic [REM_W-1:0]     rem_reg;
    logic [REM_W-1:0]     rem_next;
    logic [DW-1:0]        quot_reg;
    logic [DW-1:0]        quot_next;
    logic                 fail_reg;
    logic [REM_W:0]       shifted;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        rem_next  = in_rem;
        quot_next = in_quot;
        shifted   = '0;
        for (int j = BPS - 1; j >= 0; j--)
        begin
            shifted = {rem_next, DIGITS[j]};
            if (shifted >= {1'b0, in_divisor})
            begin
                rem_next  = REM_W'(shifted - {1'b0, in_divisor});
                quot_next = {quot_next[DW-2:0], 1'b1};
            end
            else
            begin
                rem_next  = shifted[REM_W-1:0];
                quot_next = {quot_next[DW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready)
        begin
            divisor_reg <= in_divisor;
            rem_reg     <= rem_next;
            quot_reg    <= quot_next;
            fail_reg    <= in_fail;
        end
    end

    assign out_valid   = valid_reg;
    assign out_divisor = divisor_reg;
    assign out_rem     = rem_reg;
    assign out_quot    = quot_reg;
    assign out_fail    = fail_reg;

endmodule

`default_nettype wire

// ===== sv/tpc_select.sv =====
// prescaler choice from the quotient, with the result register
`default_nettype none

module tpc_select #(
    parameter int DW = 2
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [DW-1:0]        in_quot,
    input  wire logic                 in_fail,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output tpc_pkg::tpc_result_t      out_result
);
    import tpc_pkg::*;

    logic         valid_reg;
    tpc_result_t  result_reg;
    tpc_result_t  result_next;
    logic [63:0]  ticks;

    assign in_ready = !valid_reg || out_ready;

    // half period in core clock ticks
    assign ticks = 64'(in_quot[DW-1:1]);

    always_comb
    begin
        result_next = '0;
        result_next.sel = SEL_NONE;
        if (!in_fail)
        begin
            priority if (ticks <= COUNT_MAX)
            begin
                result_next.ok    = 1'b1;
                result_next.sel   = SEL_DIV1;
                result_next.count = ticks[COUNT_W-1:0];
            end
            else if ((ticks >> 3) <= COUNT_MAX)
            begin
                result_next.ok    = 1'b1;
                result_next.sel   = SEL_DIV8;
                result_next.count = ticks[COUNT_W+2:3];
            end
            else if ((ticks >> 6) <= COUNT_MAX)
            begin
                result_next.ok    = 1'b1;
                result_next.sel   = SEL_DIV64;
                result_next.count = ticks[COUNT_W+5:6];
            end
            else if ((ticks >> 8) <= COUNT_MAX)
            begin
                result_next.ok    = 1'b1;
                result_next.sel   = SEL_DIV256;
                result_next.count = ticks[COUNT_W+7:8];
            end
            else if ((ticks >> 10) <= COUNT_MAX)
            begin
                result_next.ok    = 1'b1;
                result_next.sel   = SEL_DIV1024;
                result_next.count = ticks[COUNT_W+9:10];
            end
            else
            begin
                result_next.ok  = 1'b0;
                result_next.sel = SEL_NONE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid  = valid_reg;
    assign out_result = result_reg;

endmodule

`default_nettype wire

// ===== sv/timer_prescale_compare_calc.sv =====
// timer prescaler and compare count calculator, top level
//
//   channel  dir  handshake              beat
//   req      in   req_valid / req_stall  frequency
//   rsp      out  rsp_valid / rsp_stall  ok, prescale_select, compare_count
//
// one beat per cycle while rsp is not stalled; each beat passes through
// the divider stages, which each resolve two quotient bits, and then
// the result register
// reset clears only the stage valid bits
// a stall on rsp holds the result; upstream stages keep filling empty slots
`default_nettype none

module timer_prescale_compare_calc #(
    parameter int CORE_CLOCK_HZ = 8000000,
    parameter int FREQ_SCALE = 100
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       req_valid,
    output logic                            req_stall,
    input  wire logic [tpc_pkg::FREQ_W-1:0] frequency,
    output logic                            rsp_valid,
    input  wire logic                       rsp_stall,
    output logic                            ok,
    output logic [2:0]                      prescale_select,
    output logic [tpc_pkg::COUNT_W-1:0]     compare_count
);
    import tpc_pkg::*;

    `include "timer_prescale_compare_calc_macros.svh"

    localparam logic [63:0] DIVIDEND   = 64'(FREQ_SCALE) * 64'(CORE_CLOCK_HZ);
    localparam int          NW         = $clog2(DIVIDEND + 64'd1);
    localparam int          NS         = (NW + DIV_BITS_PER_STAGE - 1) / DIV_BITS_PER_STAGE;
    localparam int          DW         = NS * DIV_BITS_PER_STAGE;
    localparam logic [DW-1:0] DIVIDEND_DW = DW'(DIVIDEND);
    // frequency / FREQ_SCALE > CORE_CLOCK_HZ  <=>  frequency >= this
    localparam logic [63:0] FREQ_LIMIT = (64'(CORE_CLOCK_HZ) + 64'd1) * 64'(FREQ_SCALE);

    logic               stg_valid   [NS+1];
    logic               stg_ready   [NS+1];
    logic [FREQ_W-1:0]  stg_divisor [NS+1];
    logic [REM_W-1:0]   stg_rem     [NS+1];
    logic [DW-1:0]      stg_quot    [NS+1];
    logic               stg_fail    [NS+1];
    tpc_result_t        result;

    assign stg_valid[0]   = req_valid;
    assign stg_divisor[0] = frequency;
    assign stg_rem[0]     = '0;
    assign stg_quot[0]    = '0;
    assign stg_fail[0]    = (frequency == '0) || (64'(frequency) >= FREQ_LIMIT);
    assign req_stall      = !stg_ready[0];

    for (genvar s = 0; s < NS; s++)
    begin : g_div
        tpc_div_stage #(
            .DW       (DW),
            .STAGE    (s),
            .DIVIDEND (DIVIDEND_DW)
        ) u_stage (
            .clk         (clk),
            .rst_n       (rst_n),
            .in_valid    (stg_valid[s]),
            .in_ready    (stg_ready[s]),
            .in_divisor  (stg_divisor[s]),
            .in_rem      (stg_rem[s]),
            .in_quot     (stg_quot[s]),
            .in_fail     (stg_fail[s]),
            .out_valid   (stg_valid[s+1]),
            .out_ready   (stg_ready[s+1]),
            .out_divisor (stg_divisor[s+1]),
            .out_rem     (stg_rem[s+1]),
            .out_quot    (stg_quot[s+1]),
            .out_fail    (stg_fail[s+1])
        );
    end

    tpc_select #(
        .DW (DW)
    ) u_select (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (stg_valid[NS]),
        .in_ready   (stg_ready[NS]),
        .in_quot    (stg_quot[NS]),
        .in_fail    (stg_fail[NS]),
        .out_valid  (rsp_valid),
        .out_ready  (!rsp_stall),
        .out_result (result)
    );

    assign ok              = result.ok;
    assign prescale_select = result.sel;
    assign compare_count   = result.count;

    // success always carries a real prescaler code
    `TPC_ASSERT_IMPLIES(a_ok_sel, clk, rst_n, rsp_valid && ok, (prescale_select == SEL_DIV1) || (prescale_select == SEL_DIV8) || (prescale_select == SEL_DIV64) || (prescale_select == SEL_DIV256) || (prescale_select == SEL_DIV1024))
    `TPC_ASSERT_IMPLIES(a_fail_zero, clk, rst_n, rsp_valid && !ok, (prescale_select == SEL_NONE) && (compare_count == '0))
    // a coarser prescaler is picked only when the finer one overflowed
    `TPC_ASSERT_IMPLIES(a_coarse_min, clk, rst_n, rsp_valid && ok && (prescale_select != SEL_DIV1), compare_count >= 16'h2000)
    // last divider stage holds its quotient while blocked
    `TPC_ASSERT_NEXT(a_div_hold, clk, rst_n, stg_valid[NS] && !stg_ready[NS], stg_valid[NS] && $stable(stg_quot[NS]))

endmodule

`default_nettype wire
